// ===== rtl/spngd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spngd_pkg
// Shared types and constants of the sensor packet nibble group decoder.
// ----------------------------------------------------------------------------
package spngd_pkg;

    localparam int unsigned SLOT_W     = 6;              // tag:nibble of one byte
    localparam int unsigned WINDOW_W   = 3 * SLOT_W;     // three pending bytes
    localparam int unsigned DIST_W     = 14;
    localparam int unsigned LIMIT_W    = 14;
    localparam int unsigned GROUP_W    = 16;             // four nibbles
    localparam int unsigned SCALE_W    = 12;
    localparam int unsigned PRODUCT_W  = GROUP_W + SCALE_W;
    localparam int unsigned FULL_SCALE_SHIFT = 14;       // divide by 0x4000

    localparam logic [DIST_W-1:0]  BASE_MM = 14'd2500;
    localparam logic [SCALE_W-1:0] SPAN_MM = 12'd2500;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_LIMIT  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_LIMIT = 4'd1;

    // per-port scan state, window oldest byte in bits 5:0
    typedef struct packed {
        logic [WINDOW_W-1:0] window_bytes;
        logic [1:0]          window_fill;
        logic [DIST_W-1:0]   held_distance;
        logic                found_flag;
    } win_state_t;

endpackage
`default_nettype wire

// ===== rtl/sensor_packet_nibble_group_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_packet_nibble_group_decoder
// Per-port packet scanner: finds four-byte groups with matching tags,
// scales them to a distance and reports one word per finished packet.
// ----------------------------------------------------------------------------
// result path: a packet's closing byte passes the input register, then the
//   result register, before its result word shows on m_tvalid
// throughput: one input word per cycle, any port mix; the input stalls only
//   while a result word waits on m_tready
// reset: aresetn synchronous, active low; clears all port state, empties
//   both pipeline registers and loads low/high limits with 2500/5000
module sensor_packet_nibble_group_decoder
    import spngd_pkg::*;
#(
    parameter int unsigned NUM_SENSOR_PORTS = 8,
    parameter int unsigned PACKET_BYTES     = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]     cfg_data,

    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] data_byte
    input  wire logic [2:0]             s_tuser,   // [2:0] port

    // result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [15:0]                 m_tdata,   // [13:0] distance,
                                                   // [14] out_of_range,
                                                   // [15] group_found
    output logic [2:0]                  m_tuser    // [2:0] result_port
);

    localparam int unsigned PIDX_W = (NUM_SENSOR_PORTS > 1) ? $clog2(NUM_SENSOR_PORTS) : 1;
    localparam int unsigned CNT_W  = $clog2(PACKET_BYTES);
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(PACKET_BYTES - 1);

    // ---- configuration registers, always ready
    logic [LIMIT_W-1:0] low_limit_reg;
    logic [LIMIT_W-1:0] high_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= LIMIT_W'(2500);
            high_limit_reg <= LIMIT_W'(5000);
        end else if (cfg_valid) begin
            if (cfg_index == CFG_LOW_LIMIT) begin
                low_limit_reg <= cfg_data;
            end
            if (cfg_index == CFG_HIGH_LIMIT) begin
                high_limit_reg <= cfg_data;
            end
        end
    end

    // ---- input register
    logic       in_valid_reg;
    logic [2:0] in_port_reg;
    logic [7:0] in_byte_reg;
    logic       advance;

    logic       out_valid_reg;
    logic [2:0] out_port_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic       out_oor_reg;
    logic       out_found_reg;

    // scan stage moves when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_port_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // ---- per-port state, read at the port in the scan stage
    logic [CNT_W-1:0] byte_count_reg [NUM_SENSOR_PORTS];
    win_state_t       win_state_reg  [NUM_SENSOR_PORTS];

    logic [PIDX_W-1:0] pidx;
    logic              port_ok;
    logic              last_byte;
    win_state_t        cur_state;
    win_state_t        state_next;
    logic [CNT_W-1:0]  count_next;

    // ports without a channel are dropped without a trace
    assign port_ok   = {29'd0, in_port_reg} < NUM_SENSOR_PORTS;
    assign pidx      = PIDX_W'(in_port_reg);
    assign cur_state = win_state_reg[pidx];
    assign last_byte = (byte_count_reg[pidx] == LAST_COUNT);
    assign count_next = last_byte ? '0 : byte_count_reg[pidx] + CNT_W'(1);

    spngd_group_unit u_group (
        .cur_slot  (in_byte_reg[SLOT_W-1:0]),
        .state_in  (cur_state),
        .state_out (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SENSOR_PORTS; i++) begin
                byte_count_reg[i] <= '0;
                win_state_reg[i]  <= '0;
            end
        end else if (advance && port_ok) begin
            byte_count_reg[pidx] <= count_next;
            // packet end drops pending bytes and the held group
            win_state_reg[pidx]  <= last_byte ? '0 : state_next;
        end
    end

    // ---- result register
    logic emit;
    logic oor_next;

    assign emit     = advance && port_ok && last_byte;
    assign oor_next = (state_next.held_distance > high_limit_reg) ||
                      (state_next.held_distance < low_limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_port_reg  <= in_port_reg;
            out_dist_reg  <= state_next.held_distance;
            out_oor_reg   <= oor_next;
            out_found_reg <= state_next.found_flag;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_found_reg, out_oor_reg, out_dist_reg};
    assign m_tuser  = out_port_reg;

endmodule
`default_nettype wire

// ===== rtl/spngd_group_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spngd_group_unit
// One scan step: pushes a byte into a port's window, decodes a full group.
// ----------------------------------------------------------------------------
module spngd_group_unit
    import spngd_pkg::*;
(
    input  wire logic [SLOT_W-1:0] cur_slot,
    input  wire win_state_t        state_in,
    output win_state_t             state_out
);

    logic [1:0]           tag;
    logic [WINDOW_W-1:0]  w;
    logic                 hit;
    logic [GROUP_W-1:0]   group_val;
    logic [PRODUCT_W-1:0] product;
    logic [DIST_W-1:0]    scaled;

    assign tag = cur_slot[5:4];
    assign w   = state_in.window_bytes;

    assign hit = (state_in.window_fill == 2'd3) &&
                 (w[5:4] == tag) && (w[11:10] == tag) && (w[17:16] == tag);

    // first byte in the least significant nibble
    assign group_val = {cur_slot[3:0], w[15:12], w[9:6], w[3:0]};
    assign product   = PRODUCT_W'(group_val) * PRODUCT_W'(SPAN_MM);
    assign scaled    = BASE_MM + DIST_W'(product >> FULL_SCALE_SHIFT);

    always_comb begin
        state_out = state_in;
        if (hit) begin
            state_out.held_distance = scaled;
            state_out.found_flag    = 1'b1;
            state_out.window_bytes  = '0;
            state_out.window_fill   = 2'd0;
        end else begin
            unique case (state_in.window_fill)
                2'd0: state_out.window_bytes = {w[17:6], cur_slot};
                2'd1: state_out.window_bytes = {w[17:12], cur_slot, w[5:0]};
                2'd2: state_out.window_bytes = {cur_slot, w[11:0]};
                default: state_out.window_bytes = {cur_slot, w[17:6]};
            endcase
            if (state_in.window_fill != 2'd3) begin
                state_out.window_fill = state_in.window_fill + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire
